FILE: rtl/btree_internal_node_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// btree internal node engine - assertion macros
// shared property wrappers, clocked on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BTREE_INTERNAL_NODE_ENGINE_UNIT_MACROS_SVH
`define BTREE_INTERNAL_NODE_ENGINE_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BTINE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define BTINE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/btine_pkg.sv
// ----------------------------------------------------------------------------
// btine_pkg
// types, codes and defaults shared by the b+ tree internal node engine
// ----------------------------------------------------------------------------
package btine_pkg;

	localparam int NODE_CAPACITY = 64;
	localparam int KEY_WIDTH_DEF = 32;

	localparam int ID_W   = 32;
	localparam int RAWK_W = 32;
	localparam int SLOT_W = 6;
	localparam int CNT_W  = 7;
	localparam int OP_W   = 3;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(64);

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 3'd0,
		OP_FIND   = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_ROOT   = 3'd4,
		OP_TAKE   = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_NOT_FOUND  = 2'd1,
		ST_FULL       = 2'd2,
		ST_SLOT_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		op_t                       op;
		logic signed [RAWK_W-1:0]  search_key;
		logic signed [ID_W-1:0]    child_id;
		logic signed [ID_W-1:0]    new_child_id;
		logic [SLOT_W-1:0]         slot;
	} cmd_t;

	typedef struct packed {
		logic signed [ID_W-1:0] child;
		logic [SLOT_W-1:0]      slot;
		logic [CNT_W-1:0]       count;
		status_t                status;
	} res_t;

endpackage

FILE: rtl/btine_core.sv
// ----------------------------------------------------------------------------
// btine_core
// node storage, sequencer and the shared compare unit; one entry per cycle
// ----------------------------------------------------------------------------
module btine_core #(
	parameter int KEY_WIDTH = btine_pkg::KEY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  btine_pkg::cmd_t               cmd,
	input  logic [btine_pkg::CNT_W-1:0]   max_entries,
	input  logic                          res_ready,
	output logic                          idle,
	output logic                          done,
	output btine_pkg::res_t               res
);
	import btine_pkg::*;

	localparam int AW = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_SHIFT = 8'b0000_0100,
		S_PUT   = 8'b0000_1000,
		S_ROOT0 = 8'b0001_0000,
		S_ROOT1 = 8'b0010_0000,
		S_TAKE  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	// storage
	logic [KEY_WIDTH-1:0] key_mem   [NODE_CAPACITY];
	logic [ID_W-1:0]      child_mem [NODE_CAPACITY];
	logic [KEY_WIDTH-1:0] key_rd_s1;
	logic [ID_W-1:0]      child_rd_s1;

	// control
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             rd_vld_s1, rd_vld_d;
	logic             issue_q, issue_d;

	// payload
	op_t                  op_q, op_d;
	logic [KEY_WIDTH-1:0] key_q, key_d;
	logic [ID_W-1:0]      cid_q, cid_d;
	logic [ID_W-1:0]      ncid_q, ncid_d;
	logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]     rd_at_s1, rd_at_d;
	logic [CNT_W-1:0]     last_idx_q, last_idx_d;
	logic [CNT_W-1:0]     pos_q, pos_d;
	logic [ID_W-1:0]      res_child_q, res_child_d;
	logic [SLOT_W-1:0]    res_slot_q, res_slot_d;
	status_t              res_status_q, res_status_d;

	logic [63:0]          key_ext;
	logic [KEY_WIDTH-1:0] key_in;
	logic                 key_ge;
	logic                 child_eq;
	logic                 hit;
	logic                 cap_full;
	logic [CNT_W-1:0]     slot_ext;
	logic [CNT_W-1:0]     slot_nxt;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [KEY_WIDTH-1:0] wr_key;
	logic [ID_W-1:0]      wr_child;
	logic [AW-1:0]        rd_addr;

	assign key_ext  = {{32{cmd.search_key[RAWK_W-1]}}, cmd.search_key};
	assign key_in   = key_ext[KEY_WIDTH-1:0];
	assign slot_ext = CNT_W'(cmd.slot);
	assign slot_nxt = slot_ext + CNT_W'(1);

	// shared compare unit, fed from the registered read port
	assign key_ge   = $signed(key_q) >= $signed(key_rd_s1);
	assign child_eq = child_rd_s1 == cid_q;
	// slot 0 ends a lookup scan without a key compare
	assign hit      = (op_q == OP_LOOKUP) ? ((rd_at_s1 == '0) || key_ge) : child_eq;
	assign cap_full = (cnt_q >= max_entries) || (int'(cnt_q) >= NODE_CAPACITY);

	assign rd_addr = AW'(rd_idx_q);

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		rd_vld_d     = 1'b0;
		issue_d      = issue_q;
		op_d         = op_q;
		key_d        = key_q;
		cid_d        = cid_q;
		ncid_d       = ncid_q;
		rd_idx_d     = rd_idx_q;
		rd_at_d      = rd_at_s1;
		last_idx_d   = last_idx_q;
		pos_d        = pos_q;
		res_child_d  = res_child_q;
		res_slot_d   = res_slot_q;
		res_status_d = res_status_q;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_key       = key_q;
		wr_child     = ncid_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d         = cmd.op;
					key_d        = key_in;
					cid_d        = cmd.child_id;
					ncid_d       = cmd.new_child_id;
					res_child_d  = '0;
					res_slot_d   = '0;
					res_status_d = ST_OK;
					state_d      = S_DONE;
					case (cmd.op)
						OP_LOOKUP: begin
							if (cnt_q == '0) begin
								res_status_d = ST_NOT_FOUND;
							end else begin
								state_d  = S_SCAN;
								rd_idx_d = cnt_q - CNT_W'(1);
							end
						end
						OP_FIND, OP_INSERT: begin
							if (cnt_q == '0) begin
								res_status_d = ST_NOT_FOUND;
							end else begin
								state_d  = S_SCAN;
								rd_idx_d = '0;
							end
						end
						OP_REMOVE: begin
							if (slot_ext >= cnt_q) begin
								res_status_d = ST_SLOT_RANGE;
							end else if (slot_nxt < cnt_q) begin
								state_d    = S_SHIFT;
								issue_d    = 1'b1;
								rd_idx_d   = slot_nxt;
								last_idx_d = cnt_q - CNT_W'(1);
							end else begin
								cnt_d = cnt_q - CNT_W'(1);
							end
						end
						OP_ROOT: state_d = S_ROOT0;
						OP_TAKE: begin
							state_d  = S_TAKE;
							rd_idx_d = '0;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (rd_vld_s1 && hit) begin
					state_d = S_DONE;
					case (op_q)
						OP_LOOKUP: res_child_d = child_rd_s1;
						OP_FIND:   res_slot_d  = rd_at_s1[SLOT_W-1:0];
						OP_INSERT: begin
							pos_d = rd_at_s1;
							if (cap_full) begin
								res_status_d = ST_FULL;
							end else if (rd_at_s1 + CNT_W'(1) < cnt_q) begin
								state_d    = S_SHIFT;
								issue_d    = 1'b1;
								rd_idx_d   = cnt_q - CNT_W'(1);
								last_idx_d = rd_at_s1 + CNT_W'(1);
							end else begin
								state_d = S_PUT;
							end
						end
						default: ;
					endcase
				end else if (rd_vld_s1 && (rd_at_s1 == cnt_q - CNT_W'(1))
						&& (op_q != OP_LOOKUP)) begin
					res_status_d = ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					// keep one read in flight ahead of the compare
					rd_vld_d = 1'b1;
					rd_at_d  = rd_idx_q;
					rd_idx_d = (op_q == OP_LOOKUP) ? rd_idx_q - CNT_W'(1)
						: rd_idx_q + CNT_W'(1);
				end
			end
			S_SHIFT: begin
				// insert walks down and writes one up, remove walks up and writes one down
				wr_en    = rd_vld_s1;
				wr_addr  = (op_q == OP_INSERT) ? AW'(rd_at_s1 + CNT_W'(1))
					: AW'(rd_at_s1 - CNT_W'(1));
				wr_key   = key_rd_s1;
				wr_child = child_rd_s1;
				if (issue_q) begin
					rd_vld_d = 1'b1;
					rd_at_d  = rd_idx_q;
					if (rd_idx_q == last_idx_q) begin
						issue_d = 1'b0;
					end else begin
						rd_idx_d = (op_q == OP_INSERT) ? rd_idx_q - CNT_W'(1)
							: rd_idx_q + CNT_W'(1);
					end
				end else if (!rd_vld_s1) begin
					if (op_q == OP_INSERT) begin
						state_d = S_PUT;
					end else begin
						cnt_d   = cnt_q - CNT_W'(1);
						state_d = S_DONE;
					end
				end
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = AW'(pos_q + CNT_W'(1));
				cnt_d   = cnt_q + CNT_W'(1);
				state_d = S_DONE;
			end
			S_ROOT0: begin
				wr_en    = 1'b1;
				wr_addr  = '0;
				wr_child = cid_q;
				state_d  = S_ROOT1;
			end
			S_ROOT1: begin
				wr_en   = 1'b1;
				wr_addr = AW'(1);
				cnt_d   = CNT_W'(2);
				state_d = S_DONE;
			end
			S_TAKE: begin
				if (!rd_vld_s1) begin
					rd_vld_d = 1'b1;
					rd_at_d  = rd_idx_q;
				end else begin
					res_child_d = child_rd_s1;
					cnt_d       = '0;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			issue_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rd_vld_s1 <= rd_vld_d;
			issue_q   <= issue_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		key_q        <= key_d;
		cid_q        <= cid_d;
		ncid_q       <= ncid_d;
		rd_idx_q     <= rd_idx_d;
		rd_at_s1     <= rd_at_d;
		last_idx_q   <= last_idx_d;
		pos_q        <= pos_d;
		res_child_q  <= res_child_d;
		res_slot_q   <= res_slot_d;
		res_status_q <= res_status_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]   <= wr_key;
			child_mem[wr_addr] <= wr_child;
		end
		key_rd_s1   <= key_mem[rd_addr];
		child_rd_s1 <= child_mem[rd_addr];
	end

	assign idle       = state_q == S_IDLE;
	assign done       = (state_q == S_DONE) && res_ready;
	assign res.child  = res_child_q;
	assign res.slot   = res_slot_q;
	assign res.count  = cnt_q;
	assign res.status = res_status_q;

endmodule

FILE: rtl/btree_internal_node_engine_unit.sv
// ----------------------------------------------------------------------------
// btree_internal_node_engine_unit
// one b+ tree internal node: routing lookup, child search, insert and remove
// ----------------------------------------------------------------------------
// s_* takes one command item: s_tuser holds the op, s_tdata the key, ids and
// slot. m_* returns exactly one result item per command: child, slot and entry
// count in m_tdata, the status code in m_tuser. cfg_we/cfg_wdata set the
// max_entries limit (64 after reset); the user must write them only while the
// engine is idle; the block does not enforce it. One item is worked at a time
// and s_tready is low until its result has been handed to the output register.
// The node memory has one read and one write port, so scans and shifts move
// one entry per cycle. Lookup and find child scan the entries; insert runs the
// find scan, shifts the entries after the child up and writes the new entry;
// remove shifts the entries after the slot down; new root fills slots 0 and 1
// and take only child reads slot 0.
// The result sits in an output register; a stalled receiver holds it there and
// the engine finishes its next item into a wait state until the register frees.
// Reset empties the node (entry count zero) and clears both valids; the node
// memory itself is not cleared.
// ----------------------------------------------------------------------------
module btree_internal_node_engine_unit #(
	parameter int KEY_WIDTH = btine_pkg::KEY_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// search_key [31:0], child_id [63:32], new_child_id [95:64], slot [101:96]
	input  logic [103:0] s_tdata,
	// op [2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// child_out [31:0], slot_out [37:32], count_out [44:38]
	output logic [47:0]  m_tdata,
	// status [1:0]
	output logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata
);
	import btine_pkg::*;

	`include "btree_internal_node_engine_unit_macros.svh"

	cmd_t             cmd;
	res_t             res;
	logic             core_idle;
	logic             core_done;
	logic             res_ready;
	logic             start;
	logic [CNT_W-1:0] max_entries_q;
	logic             m_tvalid_q;
	logic [47:0]      m_tdata_q;
	logic [1:0]       m_tuser_q;

	assign cmd.op           = op_t'(s_tuser[OP_W-1:0]);
	assign cmd.search_key   = s_tdata[31:0];
	assign cmd.child_id     = s_tdata[63:32];
	assign cmd.new_child_id = s_tdata[95:64];
	assign cmd.slot         = s_tdata[101:96];

	assign s_tready  = core_idle;
	assign start     = s_tvalid && core_idle;
	assign res_ready = !m_tvalid_q || m_tready;

	btine_core #(
		.KEY_WIDTH(KEY_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.max_entries(max_entries_q),
		.res_ready  (res_ready),
		.idle       (core_idle),
		.done       (core_done),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			max_entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (core_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			m_tdata_q <= {3'b000, res.count, res.slot, res.child};
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`BTINE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
		"engine still ready after taking an item")
	`BTINE_ASSERT_SAME(a_count_in_capacity, m_tvalid, int'(m_tdata[44:38]) <= NODE_CAPACITY,
		"entry count beyond node capacity")
	`BTINE_ASSERT_SAME(a_miss_has_no_payload, m_tvalid && (m_tuser == ST_NOT_FOUND),
		(m_tdata[31:0] == '0) && (m_tdata[37:32] == '0),
		"missing child result carries a child or slot")

endmodule
